>>> hw/rtl/hdlcms_pkg.sv
`timescale 1ns / 1ps

package hdlcms_pkg;

  // frame delimiter byte
  localparam logic [7:0] FLAG_BYTE = 8'h7E;

  // saturation limits of the tick counters
  localparam logic [11:0] IDLE_MAX = 12'hFFF;
  localparam logic [7:0]  POLL_MAX = 8'hFF;

  // highest sequence number in the command loop
  localparam logic [3:0] SEQ_CMD_MAX = 4'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_POLL_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] CFG_PARAM_COUNT   = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0]  POLL_PERIOD_RST   = 8'd200;
  localparam logic [11:0] TIMEOUT_TICKS_RST = 12'd2000;
  localparam logic [4:0]  PARAM_COUNT_RST   = 5'd13;

  // frame action requested from the packer / unpacker
  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_SET_ADDR  = 4'd1,
    ACT_SEND_CFG  = 4'd2,
    ACT_CHECK_CFG = 4'd3,
    ACT_SEND_AUTH = 4'd4,
    ACT_CHK_AUTH  = 4'd5,
    ACT_SEND_CMD  = 4'd6,
    ACT_STORE_ANS = 4'd7,
    ACT_SEND_DISC = 4'd8,
    ACT_TAKE_DISC = 4'd9
  } action_e;

  // result of one tick step
  typedef struct packed {
    action_e    action;
    logic [3:0] seq_number;
    logic [3:0] param_index;
    logic       timed_out;
    logic       release_frame;
  } sess_res_t;

  // result of one byte step
  typedef struct packed {
    logic       byte_store;
    logic [6:0] store_position;
    logic       frame_complete;
    logic       overflow;
  } cap_res_t;

endpackage

>>> hw/rtl/hdlcms_session.sv
`timescale 1ns / 1ps

module hdlcms_session import hdlcms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        answer_ok_i,
  input  logic        frame_held_i,
  input  logic [7:0]  poll_period_i,
  input  logic [11:0] timeout_ticks_i,
  input  logic [4:0]  param_count_i,
  output sess_res_t   res_o
);

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_SEND_CFG  = 4'd2,
    ST_WAIT_CFG  = 4'd3,
    ST_SEND_AUTH = 4'd4,
    ST_WAIT_AUTH = 4'd5,
    ST_SEND_CMD  = 4'd6,
    ST_WAIT_CMD  = 4'd7,
    ST_SEND_DISC = 4'd8,
    ST_WAIT_DISC = 4'd9
  } state_e;

  state_e      state_q, state_d;
  logic        await_q, await_d;
  logic [7:0]  poll_q, poll_d;
  logic [11:0] idle_q, idle_d;
  logic [3:0]  seq_q, seq_d;
  logic [3:0]  slot_q, slot_d;

  logic [7:0]  poll_inc;
  logic [11:0] idle_inc;
  logic [3:0]  seq_inc;
  logic [4:0]  slot_inc;

  // one tick: counters, then a poll when the divider expires
  always_comb begin
    poll_inc = (poll_q < POLL_MAX) ? poll_q + 8'd1 : poll_q;
    idle_inc = (idle_q < IDLE_MAX) ? idle_q + 12'd1 : idle_q;
    seq_inc  = seq_q + 4'd1;
    slot_inc = {1'b0, slot_q} + 5'd1;

    state_d = state_q;
    await_d = await_q;
    poll_d  = poll_inc;
    idle_d  = idle_inc;
    seq_d   = seq_q;
    slot_d  = slot_q;
    res_o   = '0;

    if (poll_inc >= poll_period_i) begin
      poll_d = '0;
      // idle timeout forces a disconnect
      if (idle_inc >= timeout_ticks_i) begin
        idle_d          = '0;
        state_d         = ST_SEND_DISC;
        await_d         = 1'b0;
        seq_d           = '0;
        slot_d          = '0;
        seq_inc         = 4'd1;
        slot_inc        = 5'd1;
        res_o.timed_out = 1'b1;
      end
      if (!(await_d && !frame_held_i)) begin
        case (state_d)
          ST_IDLE: begin
            res_o.action = ACT_SET_ADDR;
            state_d      = ST_SEND_CFG;
            idle_d       = '0;
          end
          ST_SEND_CFG: begin
            res_o.action = ACT_SEND_CFG;
            state_d      = ST_WAIT_CFG;
            idle_d       = '0;
            await_d      = 1'b1;
          end
          ST_WAIT_CFG: begin
            res_o.action = ACT_CHECK_CFG;
            if (answer_ok_i) begin
              state_d             = ST_SEND_AUTH;
              res_o.release_frame = 1'b1;
              await_d             = 1'b0;
            end else begin
              state_d = ST_IDLE;
            end
          end
          ST_SEND_AUTH: begin
            res_o.action     = ACT_SEND_AUTH;
            res_o.seq_number = seq_d;
            seq_d            = seq_inc;
            state_d          = ST_WAIT_AUTH;
            await_d          = 1'b1;
            idle_d           = '0;
          end
          ST_WAIT_AUTH: begin
            res_o.action = ACT_CHK_AUTH;
            if (answer_ok_i) begin
              state_d             = ST_SEND_CMD;
              res_o.release_frame = 1'b1;
              await_d             = 1'b0;
            end
          end
          ST_SEND_CMD: begin
            res_o.action      = ACT_SEND_CMD;
            res_o.seq_number  = seq_d;
            res_o.param_index = slot_d;
            seq_d             = (seq_inc > SEQ_CMD_MAX) ? 4'd0 : seq_inc;
            state_d           = ST_WAIT_CMD;
            idle_d            = '0;
            await_d           = 1'b1;
          end
          ST_WAIT_CMD: begin
            res_o.action        = ACT_STORE_ANS;
            res_o.param_index   = slot_d;
            slot_d              = (slot_inc >= param_count_i || slot_inc[4]) ?
                                  4'd0 : slot_inc[3:0];
            state_d             = ST_SEND_CMD;
            await_d             = 1'b0;
            res_o.release_frame = 1'b1;
          end
          ST_SEND_DISC: begin
            res_o.action = ACT_SEND_DISC;
            state_d      = ST_WAIT_DISC;
            idle_d       = '0;
            await_d      = 1'b1;
          end
          ST_WAIT_DISC: begin
            res_o.action        = ACT_TAKE_DISC;
            state_d             = ST_IDLE;
            await_d             = 1'b0;
            res_o.release_frame = 1'b1;
          end
          default: begin
            res_o.action = ACT_NONE;
          end
        endcase
      end
    end
  end

  // session state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      await_q <= 1'b0;
      poll_q  <= '0;
      idle_q  <= '0;
      seq_q   <= '0;
      slot_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      await_q <= await_d;
      poll_q  <= poll_d;
      idle_q  <= idle_d;
      seq_q   <= seq_d;
      slot_q  <= slot_d;
    end
  end

endmodule

>>> hw/rtl/hdlcms_capture.sv
`timescale 1ns / 1ps

module hdlcms_capture import hdlcms_pkg::*; #(
  parameter int BUF_DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  input  logic       release_i,
  output logic       frame_held_o,
  output cap_res_t   res_o
);

  logic       capturing_q, capturing_d;
  logic       held_q, held_d;
  logic [7:0] head_q, head_d;
  logic       do_store;
  logic       is_flag;

  // flag-delimited capture of one byte
  always_comb begin
    is_flag     = (rx_byte_i == FLAG_BYTE);
    capturing_d = capturing_q;
    held_d      = held_q;
    head_d      = head_q;
    do_store    = 1'b0;
    res_o       = '0;

    if (!held_q) begin
      if (is_flag && !capturing_q) begin
        capturing_d = 1'b1;
        do_store    = 1'b1;
      end else if (is_flag) begin
        do_store             = 1'b1;
        held_d               = 1'b1;
        capturing_d          = 1'b0;
        res_o.frame_complete = 1'b1;
      end else if (capturing_q) begin
        do_store = 1'b1;
      end
    end

    // buffer write or overflow drop
    if (do_store) begin
      if (head_q >= 8'(BUF_DEPTH)) begin
        res_o.overflow = 1'b1;
      end else begin
        res_o.byte_store     = 1'b1;
        res_o.store_position = head_q[6:0];
        head_d               = head_q + 8'd1;
      end
    end
  end

  // capture state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q <= 1'b0;
      held_q      <= 1'b0;
      head_q      <= '0;
    end else if (release_i) begin
      held_q <= 1'b0;
      head_q <= '0;
    end else if (step_i) begin
      capturing_q <= capturing_d;
      held_q      <= held_d;
      head_q      <= head_d;
    end
  end

  assign frame_held_o = held_q;

endmodule

>>> hw/rtl/hdlc_master_session_sequencer.sv
`timescale 1ns / 1ps

// channel   | dir | handshake                | payload
// s_axis    | in  | tvalid / tready          | tuser: command; tdata: rx_byte, answer_ok
// m_axis    | out | tvalid / tready          | tdata: action .. overflow (24 bits)
// cfg       | in  | cfg_we_i, no wait        | cfg_index_i, cfg_wdata_i
//
// One item per clock while the output is not stalled: a transfer is processed in the
// cycle it is accepted and its result sits in the output register on the next cycle.
// Input is taken whenever the output register is empty or being drained, so a
// held result stalls the input only while m_axis_tready_i is low.
// Reset clears the session, counters, capture state and output valid; the
// configuration registers return to 200, 2000 and 13.

module hdlc_master_session_sequencer import hdlcms_pkg::*; #(
  parameter int BUF_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] rx_byte, [8] answer_ok
  input  logic [0:0]  s_axis_tuser_i,   // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] action, [7:4] seq_number, [11:8] param_index, [12] timed_out,
  // [13] release_frame, [14] byte_store, [21:15] store_position,
  // [22] frame_complete, [23] overflow
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_wdata_i
);

  logic [7:0]  poll_period_q;
  logic [11:0] timeout_ticks_q;
  logic [4:0]  param_count_q;
  logic        out_valid_q;
  logic [23:0] out_data_q;
  logic        accept;
  logic        tick_step;
  logic        byte_step;
  logic        frame_held;
  sess_res_t   sess_res;
  cap_res_t    cap_res;
  logic [23:0] out_data_d;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign tick_step       = accept && !s_axis_tuser_i[0];
  assign byte_step       = accept && s_axis_tuser_i[0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_period_q   <= POLL_PERIOD_RST;
      timeout_ticks_q <= TIMEOUT_TICKS_RST;
      param_count_q   <= PARAM_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POLL_PERIOD:   poll_period_q   <= cfg_wdata_i[7:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata_i;
        CFG_PARAM_COUNT:   param_count_q   <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  hdlcms_session u_session (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (tick_step),
    .answer_ok_i     (s_axis_tdata_i[8]),
    .frame_held_i    (frame_held),
    .poll_period_i   (poll_period_q),
    .timeout_ticks_i (timeout_ticks_q),
    .param_count_i   (param_count_q),
    .res_o           (sess_res)
  );

  hdlcms_capture #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (byte_step),
    .rx_byte_i    (s_axis_tdata_i[7:0]),
    .release_i    (tick_step && sess_res.release_frame),
    .frame_held_o (frame_held),
    .res_o        (cap_res)
  );

  // pack the result of the accepted item
  always_comb begin
    out_data_d = '0;
    if (s_axis_tuser_i[0]) begin
      out_data_d[14]    = cap_res.byte_store;
      out_data_d[21:15] = cap_res.store_position;
      out_data_d[22]    = cap_res.frame_complete;
      out_data_d[23]    = cap_res.overflow;
    end else begin
      out_data_d[3:0]  = sess_res.action;
      out_data_d[7:4]  = sess_res.seq_number;
      out_data_d[11:8] = sess_res.param_index;
      out_data_d[12]   = sess_res.timed_out;
      out_data_d[13]   = sess_res.release_frame;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
